### hw/rtl/mcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types and constants for the maximum cut segments block.
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int MAX_LENGTH_DEF = 16383;

  localparam int LEN_W     = 14;
  localparam int CNT_W     = 15;
  localparam int CFG_IDX_W = 2;

  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_CUT_A = 2'd0;
  localparam cfg_idx_t CFG_CUT_B = 2'd1;
  localparam cfg_idx_t CFG_CUT_C = 2'd2;

endpackage

### hw/rtl/mcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/max_cut_segments_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_cut_segments_dp
// Greatest number of exact pieces of length cut_a, cut_b or cut_c into which
// a segment of in_total_length can be cut; 0 when no exact cut exists.
// ----------------------------------------------------------------------------
// Usage:
//   Write the three piece lengths through the cfg channel (index 0..2) while
//   the block is idle; cfg_ready is always high and other indexes are ignored.
//   A piece length of 0 is treated as not offered.
//   An item on the in channel is taken only while the block is idle. The
//   block then fills its table for lengths 1..n, each entry taking three
//   reads of the single table read port (one per piece length) and a write.
//   The result is then loaded into the output register from the done state,
//   and a new item is accepted only once that load has happened.
//   A length of 0, or one above MAX_LENGTH, skips the table fill and gives 0.
//   If the receiver stalls, the result waits in the output register. The
//   block still takes the next item, but holds that item's result in the
//   done state until the waiting result is taken.
//   Reset returns all piece lengths to 1 and empties the output. The table
//   needs no clearing: every entry read was written earlier in the same item.
// ----------------------------------------------------------------------------
module max_cut_segments_dp #(
  parameter int MAX_LENGTH = mcs_pkg::MAX_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mcs_pkg::len_t      in_total_length,
  output logic               out_valid,
  input  logic               out_ready,
  output mcs_pkg::len_t      out_max_pieces,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  mcs_pkg::cfg_idx_t  cfg_index,
  input  mcs_pkg::len_t      cfg_data
);
  import mcs_pkg::*;

  localparam int DEPTH = MAX_LENGTH + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (AW > LEN_W) ? AW : LEN_W;
  localparam int DW    = CNT_W + 1;
  localparam logic [IW-1:0] MAX_L = IW'(MAX_LENGTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD_A = 3'd1;
  localparam logic [2:0] S_RD_B = 3'd2;
  localparam logic [2:0] S_RD_C = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state_r, state_nxt;
  len_t          cut_a_r, cut_b_r, cut_c_r;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic          ok_r, ok_nxt;
  logic          best_v_r, best_v_nxt;
  cnt_t          best_c_r, best_c_nxt;
  cnt_t          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  len_t          out_pieces_r, out_pieces_nxt;

  len_t          cut_sel;
  logic [IW-1:0] i_ext, cut_ext, diff;
  logic          term_ok;
  logic          in_acc;
  logic [IW-1:0] n_ext;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata, rdata;

  logic          cand_v;
  cnt_t          cand_c;
  logic          merge_v;
  cnt_t          merge_c;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign n_ext     = IW'(in_total_length);

  assign out_valid      = out_valid_r;
  assign out_max_pieces = out_pieces_r;

  // Shared subtract/compare unit: i minus the piece length picked this phase.
  always_comb begin
    case (state_r)
      S_RD_A:  cut_sel = cut_a_r;
      S_RD_B:  cut_sel = cut_b_r;
      S_RD_C:  cut_sel = cut_c_r;
      default: cut_sel = cut_a_r;
    endcase
  end

  assign i_ext   = IW'(i_r);
  assign cut_ext = IW'(cut_sel);
  assign diff    = i_ext - cut_ext;
  assign term_ok = (cut_sel != '0) && (cut_ext <= i_ext);

  // Candidate from the entry read last cycle, merged with the running best.
  assign cand_v = ok_r && rdata[DW-1];
  assign cand_c = rdata[CNT_W-1:0] + cnt_t'(1);

  always_comb begin
    merge_v = best_v_r;
    merge_c = best_c_r;
    if (cand_v && (!best_v_r || (cand_c > best_c_r))) begin
      merge_v = 1'b1;
      merge_c = cand_c;
    end
  end

  mcs_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (diff[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    n_nxt          = n_r;
    ok_nxt         = term_ok;
    best_v_nxt     = best_v_r;
    best_c_nxt     = best_c_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_pieces_nxt = out_pieces_r;
    we             = 1'b0;
    waddr          = i_r;
    wdata          = {merge_v, merge_c};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // Length 0 is reachable with no pieces.
          we    = 1'b1;
          waddr = '0;
          wdata = {1'b1, cnt_t'(0)};
          i_nxt = AW'(1);
          n_nxt = n_ext[AW-1:0];
          if ((in_total_length == '0) || (n_ext > MAX_L)) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD_A;
          end
        end
      end
      S_RD_A: begin
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        best_v_nxt = cand_v;
        best_c_nxt = cand_c;
        state_nxt  = S_RD_C;
      end
      S_RD_C: begin
        best_v_nxt = merge_v;
        best_c_nxt = merge_c;
        state_nxt  = S_WR;
      end
      S_WR: begin
        we = 1'b1;
        if (!merge_v) begin
          wdata = {1'b0, cnt_t'(0)};
        end
        if (i_r == n_r) begin
          res_nxt   = merge_v ? merge_c : cnt_t'(0);
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = S_RD_A;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_pieces_nxt = res_r[LEN_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cut_a_r     <= len_t'(1);
      cut_b_r     <= len_t'(1);
      cut_c_r     <= len_t'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CUT_A: cut_a_r <= cfg_data;
          CFG_CUT_B: cut_b_r <= cfg_data;
          CFG_CUT_C: cut_c_r <= cfg_data;
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    n_r          <= n_nxt;
    ok_r         <= ok_nxt;
    best_v_r     <= best_v_nxt;
    best_c_r     <= best_c_nxt;
    res_r        <= res_nxt;
    out_pieces_r <= out_pieces_nxt;
  end

endmodule

### hw/rtl/mcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_checker
// Port-level checks for the maximum cut segments block, bound to the top.
// ----------------------------------------------------------------------------
module mcs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input mcs_pkg::len_t     out_max_pieces,
  input logic              cfg_ready
);
  import mcs_pkg::*;

  // A held result must not change or vanish while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_pieces))
    else $error("result changed or dropped while stalled");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready right after taking an item");

  // No result can show up in the cycle right after an item is taken.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too early");

  // Configuration writes are never stalled.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port stalled");

endmodule

bind max_cut_segments_dp mcs_checker u_mcs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_max_pieces (out_max_pieces),
  .cfg_ready      (cfg_ready)
);

### test/max_cut_segments_dp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_cut_segments_dp_tb
// Checks the piece counts of max_cut_segments_dp against a behavioral table
// fill. Directed items cover reset, edge lengths and piece lengths. Random
// phases then use random piece lengths, with random gaps on the input side
// and stalls on the output side in all but the first phase.
// ----------------------------------------------------------------------------
module max_cut_segments_dp_tb;
  import mcs_pkg::*;

  localparam int          MAX_LEN     = MAX_LENGTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam cfg_idx_t    CFG_UNUSED  = 2'd3;

  typedef struct {
    len_t length;
    len_t pieces;
  } piece_count_t;

  logic     clk             = 1'b0;
  logic     rst_n           = 1'b0;
  logic     in_valid        = 1'b0;
  logic     in_ready;
  len_t     in_total_length = '0;
  logic     out_valid;
  logic     out_ready       = 1'b0;
  len_t     out_max_pieces;
  logic     cfg_valid       = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index       = CFG_CUT_A;
  len_t     cfg_data        = '0;

  // Shadow copy of the piece lengths and of the table used by the predictor.
  len_t        model_cut [3] = '{14'd1, 14'd1, 14'd1};
  cnt_t        count_tab [0:MAX_LEN];
  bit          reach_tab [0:MAX_LEN];

  piece_count_t pending_pieces [$];
  int unsigned  fail_count  = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left  = 0;
  bit           gaps_on     = 1'b1;
  bit           stalls_on   = 1'b1;

  max_cut_segments_dp dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_total_length (in_total_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_max_pieces  (out_max_pieces),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bottom-up fill: entry i is 1 plus the best reachable entry i - cut.
  function automatic len_t predict_pieces(input len_t length);
    int          best;
    int          cand;
    int unsigned i;
    int unsigned c;
    if (length > MAX_LEN) return '0;
    count_tab[0] = '0;
    reach_tab[0] = 1'b1;
    for (i = 1; i <= length; i++) begin
      best = -1;
      for (int k = 0; k < 3; k++) begin
        c = model_cut[k];
        if (c != 0 && c <= i && reach_tab[i - c]) begin
          cand = int'(count_tab[i - c]) + 1;
          if (cand > best) best = cand;
        end
      end
      reach_tab[i] = (best >= 0);
      count_tab[i] = (best >= 0) ? cnt_t'(best) : '0;
    end
    return reach_tab[length] ? len_t'(count_tab[length]) : '0;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic len_t rand_cut();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 88) return len_t'($urandom_range(1, 12));
    return len_t'($urandom_range(13, 16383));
  endfunction

  function automatic len_t rand_length();
    if ($urandom_range(0, 99) < 85) return len_t'($urandom_range(0, 255));
    return len_t'($urandom_range(256, 2047));
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("max_cut_segments_dp test failed");
      $finish;
    end
  end

  // Result side: random stalls, or no new ones while stalls are switched off.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    piece_count_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pieces.size() == 0) begin
        $display("%0t: unexpected item, max_pieces %0d", $time, out_max_pieces);
        fail_count++;
      end else begin
        want = pending_pieces.pop_front();
        if (out_max_pieces !== want.pieces) begin
          $display("%0t: max_pieces for length %0d: expected %0d, actual %0d",
                   $time, want.length, want.pieces, out_max_pieces);
          fail_count++;
        end
      end
    end
  end

  // Leaves in_valid high after acceptance; the next call or wait_results
  // either replaces the item or lowers valid in that same step.
  task automatic send_item(input len_t length);
    int unsigned gap;
    gap = gaps_on ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_total_length <= length;
    do @(posedge clk); while (!in_ready);
    pending_pieces.push_back('{length: length, pieces: predict_pieces(length)});
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input len_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_CUT_C) model_cut[idx] = value;
  endtask

  task automatic set_cuts(input len_t a, input len_t b, input len_t c);
    wait_results();
    write_reg(CFG_CUT_A, a);
    write_reg(CFG_CUT_B, b);
    write_reg(CFG_CUT_C, c);
    cfg_valid <= 1'b0;
  endtask

  // Piece lengths all 1 after reset, so every length n gives n pieces.
  task automatic test_reset_cuts();
    send_item(14'd0);
    send_item(14'd1);
    send_item(14'd2);
    send_item(14'd13);
    send_item(14'h3FFF);
  endtask

  task automatic test_mixed_cuts();
    set_cuts(14'd5, 14'd3, 14'd2);
    send_item(14'd1);
    send_item(14'd4);
    send_item(14'd5);
    send_item(14'd7);
    send_item(14'd11);
    // Only even lengths can be cut exactly.
    set_cuts(14'd2, 14'd2, 14'd2);
    send_item(14'd7);
    send_item(14'd8);
  endtask

  task automatic test_zero_cuts();
    set_cuts(14'd0, 14'd0, 14'd0);
    send_item(14'd0);
    send_item(14'd5);
    send_item(14'd1);
    set_cuts(14'd0, 14'd4, 14'd0);
    send_item(14'd8);
    send_item(14'd9);
    set_cuts(14'd6, 14'd0, 14'd9);
    send_item(14'd15);
    send_item(14'd21);
  endtask

  task automatic test_widest_cuts();
    set_cuts(14'h3FFF, 14'h3FFF, 14'h3FFF);
    send_item(14'h3FFF);
    send_item(14'd100);
  endtask

  // A write to the unused index must leave the piece lengths alone.
  task automatic test_unused_index();
    set_cuts(14'd3, 14'd3, 14'd3);
    write_reg(CFG_UNUSED, 14'h3FFF);
    cfg_valid <= 1'b0;
    send_item(14'd9);
    send_item(14'd10);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      gaps_on   = (phase != 0);
      stalls_on = (phase != 0);
      set_cuts(rand_cut(), rand_cut(), rand_cut());
      for (int k = 0; k < 25; k++) begin
        if (phase == 2 && k == 12) wait_results();
        if ((phase == 1 && k == 7) || (phase == 3 && k == 20))
          send_item(len_t'($urandom_range(12000, 16383)));
        else
          send_item(rand_length());
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_cuts();
    test_mixed_cuts();
    test_zero_cuts();
    test_widest_cuts();
    test_unused_index();
    test_random();
    wait_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("max_cut_segments_dp test passed");
    end else begin
      $display("max_cut_segments_dp test failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mcs_pkg.sv
hw/rtl/mcs_ram.sv
hw/rtl/max_cut_segments_dp.sv
hw/rtl/mcs_checker.sv
test/max_cut_segments_dp_tb.sv
